[hw/rtl/wfcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcd_pkg
// Shared types, widths and helpers for the wait-for cycle detector.
// ----------------------------------------------------------------------------
package wfcd_pkg;

  // Field widths of the command word
  localparam int IDX_W  = 3;
  localparam int EDGE_W = 8;

  // Widest supported graph and the width of an index into it
  localparam int MAX_PROCS = 32;
  localparam int PTR_W     = 5;

  // Classified command word passed from the front end to the engine
  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [EDGE_W-1:0] edges;
    logic              check;
    logic              wr;
  } cmd_t;

  // Position of the lowest set bit, zero when none is set
  function automatic logic [PTR_W-1:0] lowest_set(input logic [MAX_PROCS-1:0] vec);
    logic [PTR_W-1:0] pos;
    pos = '0;
    for (int k = MAX_PROCS - 1; k >= 0; k--) begin
      if (vec[k]) begin
        pos = PTR_W'(k);
      end
    end
    return pos;
  endfunction

endpackage

[hw/rtl/wait_for_cycle_detect.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_cycle_detect
// Deadlock detector: keeps a wait-for graph, searches it for a circular wait
// on request and breaks one by clearing the first set edge.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  command   start / busy      row_index, row_edges, check
//  result    done (strobe)     cycle_found, victim_waiter, victim_holder
//
//  A row write is applied from the idle state. A check runs a depth-first
//  search, where each search step does a push, a pop or a root pick, then scans
//  the rows in order for the victim edge; both share the single matrix read port.
//  A two-word queue in front of the engine raises busy only when full.
//  Reset (rst, synchronous) empties the queue and clears the whole graph.
//  Results are shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module wait_for_cycle_detect #(
  parameter int PROCS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [wfcd_pkg::IDX_W-1:0]  row_index,
  input  logic [wfcd_pkg::EDGE_W-1:0] row_edges,
  input  logic                       check,
  output logic                       done,
  output logic                       cycle_found,
  output logic [wfcd_pkg::IDX_W-1:0] victim_waiter,
  output logic [wfcd_pkg::IDX_W-1:0] victim_holder
);

  logic           q_valid;
  logic           take;
  wfcd_pkg::cmd_t q_word;

  wfcd_front #(
    .PROCS(PROCS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .row_index (row_index),
    .row_edges (row_edges),
    .check     (check),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .take      (take)
  );

  wfcd_engine #(
    .PROCS(PROCS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .take          (take),
    .done          (done),
    .cycle_found   (cycle_found),
    .victim_waiter (victim_waiter),
    .victim_holder (victim_holder)
  );

`ifndef SYNTH
  // a clean graph reports no victim
  a_no_victim: assert property (@(posedge clk) disable iff (rst)
    done && !cycle_found |-> victim_waiter == '0 && victim_holder == '0)
    else $error("victim reported without a cycle");

  // the engine returns to idle after each strobe and must search again, so strobes never follow back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes in consecutive cycles");

  // the queue is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !busy && !done)
    else $error("queue or result live after reset");

  // the engine only takes a word the queue holds
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> q_valid)
    else $error("engine took from an empty queue");
`endif

endmodule

[hw/rtl/wfcd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcd_front
// Accepts command words, classifies them and buffers them in a two-word queue.
// ----------------------------------------------------------------------------
module wfcd_front #(
  parameter int PROCS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [wfcd_pkg::IDX_W-1:0]  row_index,
  input  logic [wfcd_pkg::EDGE_W-1:0] row_edges,
  input  logic                       check,
  output logic                       q_valid,
  output wfcd_pkg::cmd_t             q_word,
  input  logic                       take
);

  wfcd_pkg::cmd_t  word_in;
  wfcd_pkg::cmd_t  mem [2];
  logic            wp;
  logic            rp;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  // Classify: flag whether the row lies inside the graph
  always_comb begin
    word_in.row   = row_index;
    word_in.edges = row_edges;
    word_in.check = check;
    word_in.wr    = (32'(row_index) < PROCS);
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign pop     = take && q_valid;
  assign q_word  = mem[rp];

  // Store accepted words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= word_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/wfcd_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcd_engine
// Holds the wait-for matrix, runs the depth-first cycle search and clears a
// victim edge when a cycle is found.
// ----------------------------------------------------------------------------
module wfcd_engine #(
  parameter int PROCS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  wfcd_pkg::cmd_t             q_word,
  output logic                       take,
  output logic                       done,
  output logic                       cycle_found,
  output logic [wfcd_pkg::IDX_W-1:0] victim_waiter,
  output logic [wfcd_pkg::IDX_W-1:0] victim_holder
);

  localparam int IW  = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int SPW = $clog2(PROCS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_VICTIM = 3'b100
  } state_t;

  state_t                 state;
  logic [PROCS-1:0]       matrix [PROCS];
  logic [IW-1:0]          stack  [PROCS];
  logic [PROCS-1:0]       visited;
  logic [PROCS-1:0]       on_path;
  logic [SPW-1:0]         sp;
  logic [SPW-1:0]         sp_dec;
  logic [IW-1:0]          vi;
  logic [IW-1:0]          top;
  logic [IW-1:0]          rd_addr;
  logic [PROCS-1:0]       rd_row;
  logic [PROCS-1:0]       cand;
  logic [IW-1:0]          next_node;
  logic [IW-1:0]          root;
  logic [IW-1:0]          wr_addr;
  logic [PROCS-1:0]       wr_row;
  logic [wfcd_pkg::PTR_W-1:0] vi_w;
  logic [wfcd_pkg::PTR_W-1:0] hold_w;

  // Decode the current stack top and the shared matrix read port
  assign sp_dec    = sp - 1'b1;
  assign top       = stack[sp_dec[IW-1:0]];
  assign rd_addr   = (state == ST_VICTIM) ? vi : top;
  assign rd_row    = matrix[rd_addr];
  assign cand      = rd_row & ~visited;
  assign next_node = IW'(wfcd_pkg::lowest_set(wfcd_pkg::MAX_PROCS'(cand)));
  assign root      = IW'(wfcd_pkg::lowest_set(wfcd_pkg::MAX_PROCS'(~visited)));
  assign wr_addr   = IW'(q_word.row);
  assign wr_row    = PROCS'(q_word.edges);
  assign vi_w      = wfcd_pkg::PTR_W'(vi);
  assign hold_w    = wfcd_pkg::lowest_set(wfcd_pkg::MAX_PROCS'(rd_row));
  assign take      = (state == ST_IDLE) && q_valid;

  // Stack entries: push the root or the next unvisited successor
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      if (sp == '0) begin
        stack[0] <= root;
      end else if ((rd_row & on_path) == '0 && cand != '0) begin
        stack[sp[IW-1:0]] <= next_node;
      end
    end
  end

  // Control, marks, matrix and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      visited     <= '0;
      on_path     <= '0;
      sp          <= '0;
      vi          <= '0;
      done        <= 1'b0;
      cycle_found <= 1'b0;
      victim_waiter <= '0;
      victim_holder <= '0;
      for (int r = 0; r < PROCS; r++) begin
        matrix[r] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_word.wr) begin
              matrix[wr_addr] <= wr_row;
            end
            if (q_word.check) begin
              visited <= '0;
              on_path <= '0;
              sp      <= '0;
              state   <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (sp == '0) begin
            if (&visited) begin
              // every tree finished: no circular wait
              done          <= 1'b1;
              cycle_found   <= 1'b0;
              victim_waiter <= '0;
              victim_holder <= '0;
              state         <= ST_IDLE;
            end else begin
              visited[root] <= 1'b1;
              on_path[root] <= 1'b1;
              sp            <= SPW'(1);
            end
          end else if ((rd_row & on_path) != '0) begin
            // back edge onto the current path
            vi    <= '0;
            state <= ST_VICTIM;
          end else if (cand == '0) begin
            on_path[top] <= 1'b0;
            sp           <= sp_dec;
          end else begin
            visited[next_node] <= 1'b1;
            on_path[next_node] <= 1'b1;
            sp                 <= sp + 1'b1;
          end
        end
        ST_VICTIM: begin
          // scan rows in order for the first set edge and drop it
          if (rd_row != '0) begin
            matrix[vi][IW'(hold_w)] <= 1'b0;
            done          <= 1'b1;
            cycle_found   <= 1'b1;
            victim_waiter <= vi_w[wfcd_pkg::IDX_W-1:0];
            victim_holder <= hold_w[wfcd_pkg::IDX_W-1:0];
            state         <= ST_IDLE;
          end else if (32'(vi) == PROCS - 1) begin
            done          <= 1'b1;
            cycle_found   <= 1'b1;
            victim_waiter <= '0;
            victim_holder <= '0;
            state         <= ST_IDLE;
          end else begin
            vi <= vi + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/wait_for_cycle_detect_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_cycle_detect_tb
// Self-checking bench for the wait-for cycle detector. Row words are fed with
// random gaps. A scoreboard keeps its own copy of the wait-for graph and runs
// its own depth-first search for each check word. It also applies the victim
// edge clear. Every strobed verdict is compared field by field, in order.
// ----------------------------------------------------------------------------
module wait_for_cycle_detect_tb;

  localparam int PROCS      = 8;
  localparam int MAX_GAP    = 17;
  localparam int SETTLE_CYC = 100;
  localparam int RAND_WORDS = 1200;

  // Graph shapes for the random part
  typedef enum int {
    SHAPE_ACYCLIC,
    SHAPE_SPARSE,
    SHAPE_THIN,
    SHAPE_DENSE
  } graph_shape_t;

  typedef struct {
    bit                       found;
    bit [wfcd_pkg::IDX_W-1:0] waiter;
    bit [wfcd_pkg::IDX_W-1:0] holder;
  } verdict_t;

  // Predicts the verdict of each check word and queues it until it is seen
  class wait_graph_scoreboard;
    bit [PROCS-1:0] wait_rows [PROCS];
    verdict_t       verdict_q [$];
    int unsigned    failures;
    int unsigned    reported;

    function new();
      foreach (wait_rows[r]) wait_rows[r] = '0;
      failures = 0;
      reported = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // Depth-first search from every unvisited root, with an explicit stack
    function bit find_circular_wait();
      bit [PROCS-1:0] visited;
      bit [PROCS-1:0] on_path;
      int unsigned    node_stack [PROCS];
      int unsigned    cursor     [PROCS];
      int unsigned    depth;
      int unsigned    node;
      int unsigned    col;
      visited = '0;
      on_path = '0;
      for (int root = 0; root < PROCS; root++) begin
        if (visited[root]) continue;
        visited[root] = 1'b1;
        on_path[root] = 1'b1;
        node_stack[0] = root;
        cursor[0]     = 0;
        depth         = 1;
        while (depth > 0) begin
          node = node_stack[depth-1];
          col  = cursor[depth-1];
          while (col < PROCS && !wait_rows[node][col]) col++;
          if (col >= PROCS) begin
            // no edge left: pop this node off the path
            on_path[node] = 1'b0;
            depth--;
          end else begin
            cursor[depth-1] = col + 1;
            if (!visited[col]) begin
              visited[col]      = 1'b1;
              on_path[col]      = 1'b1;
              node_stack[depth] = col;
              cursor[depth]     = 0;
              depth++;
            end else if (on_path[col]) begin
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Note an accepted word: store the row, then predict a check
    function void note_word(bit [wfcd_pkg::IDX_W-1:0] idx,
                            bit [wfcd_pkg::EDGE_W-1:0] edges, bit chk);
      verdict_t v;
      bit       cleared;
      wait_rows[idx] = edges[PROCS-1:0];
      if (!chk) return;
      v = '{found: 1'b0, waiter: '0, holder: '0};
      v.found = find_circular_wait();
      cleared = 1'b0;
      // break the deadlock at the first set edge in row-major order
      if (v.found) begin
        for (int i = 0; i < PROCS; i++) begin
          for (int j = 0; j < PROCS; j++) begin
            if (!cleared && wait_rows[i][j]) begin
              wait_rows[i][j] = 1'b0;
              v.waiter        = wfcd_pkg::IDX_W'(i);
              v.holder        = wfcd_pkg::IDX_W'(j);
              cleared         = 1'b1;
            end
          end
        end
      end
      verdict_q.push_back(v);
    endfunction

    // Compare a strobed verdict with the oldest prediction
    function void check_result(bit found, bit [wfcd_pkg::IDX_W-1:0] waiter,
                               bit [wfcd_pkg::IDX_W-1:0] holder);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        flag($sformatf("unexpected verdict found=%0d waiter=%0d holder=%0d",
                       found, waiter, holder));
        return;
      end
      v = verdict_q.pop_front();
      if (found !== v.found || waiter !== v.waiter || holder !== v.holder) begin
        flag($sformatf("expected found=%0d waiter=%0d holder=%0d, got %0d/%0d/%0d",
                       v.found, v.waiter, v.holder, found, waiter, holder));
      end
    endfunction

    function void flag_leftovers();
      if (verdict_q.size() != 0) begin
        flag($sformatf("%0d verdicts never arrived", verdict_q.size()));
      end
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        start     = 1'b0;
  logic [wfcd_pkg::IDX_W-1:0]  row_index = '0;
  logic [wfcd_pkg::EDGE_W-1:0] row_edges = '0;
  logic                        check     = 1'b0;
  logic                        busy;
  logic                        done;
  logic                        cycle_found;
  logic [wfcd_pkg::IDX_W-1:0]  victim_waiter;
  logic [wfcd_pkg::IDX_W-1:0]  victim_holder;

  wait_graph_scoreboard sb = new();

  wait_for_cycle_detect #(.PROCS(PROCS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .row_index    (row_index),
    .row_edges    (row_edges),
    .check        (check),
    .done         (done),
    .cycle_found  (cycle_found),
    .victim_waiter(victim_waiter),
    .victim_holder(victim_holder)
  );

  always #5 clk = ~clk;

  // Sample each strobed verdict at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(cycle_found, victim_waiter, victim_holder);
  end

  // Present one word, hold it until accepted, then idle a random gap
  task automatic send_word(bit [wfcd_pkg::IDX_W-1:0] idx,
                           bit [wfcd_pkg::EDGE_W-1:0] edges, bit chk);
    int unsigned gap;
    start     <= 1'b1;
    row_index <= idx;
    row_edges <= edges;
    check     <= chk;
    do @(posedge clk); while (busy);
    sb.note_word(idx, edges, chk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted verdict has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
  endtask

  function automatic bit [wfcd_pkg::EDGE_W-1:0] draw_edges(graph_shape_t shape,
                                                         bit [wfcd_pkg::IDX_W-1:0] idx);
    bit [wfcd_pkg::EDGE_W-1:0] forward_mask;
    forward_mask = wfcd_pkg::EDGE_W'(8'hFF << (idx + 1));
    case (shape)
      SHAPE_ACYCLIC: draw_edges = wfcd_pkg::EDGE_W'($urandom) & forward_mask;
      SHAPE_SPARSE: begin
        draw_edges = ($urandom_range(0, 2) == 0) ? '0 :
                     wfcd_pkg::EDGE_W'(1) << $urandom_range(0, 7);
      end
      SHAPE_THIN:    draw_edges = wfcd_pkg::EDGE_W'($urandom & $urandom & $urandom);
      default:       draw_edges = wfcd_pkg::EDGE_W'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    graph_shape_t shape;
    int unsigned  sent;
    int unsigned  burst;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty graph, then each self wait at the index extremes
    send_word(3'd0, 8'h00, 1'b1);
    send_word(3'd0, 8'h01, 1'b1);
    send_word(3'd7, 8'h80, 1'b1);
    // a two-process circular wait
    send_word(3'd2, 8'h08, 1'b0);
    send_word(3'd3, 8'h04, 1'b1);
    // a ring through all processes, closed only by the check word
    for (int p = 0; p < PROCS - 1; p++) begin
      send_word(wfcd_pkg::IDX_W'(p), wfcd_pkg::EDGE_W'(1) << (p + 1), 1'b0);
    end
    send_word(3'd7, 8'h01, 1'b1);
    send_word(3'd7, 8'h00, 1'b1);
    // victim off the cycle: the 0->1 edge goes before the 5<->6 loop
    send_word(3'd0, 8'h02, 1'b0);
    send_word(3'd5, 8'h40, 1'b0);
    send_word(3'd6, 8'h20, 1'b1);
    // full rows and a clear of every row
    send_word(3'd7, 8'hFF, 1'b1);
    send_word(3'd4, 8'hFF, 1'b1);
    for (int p = 0; p < PROCS; p++) send_word(wfcd_pkg::IDX_W'(p), 8'h00, p == PROCS - 1);
    drain();

    // random rounds of one graph shape, with a rewrite of every row now and then
    sent = 0;
    while (sent < RAND_WORDS) begin
      shape = graph_shape_t'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        for (int p = 0; p < PROCS; p++) begin
          send_word(wfcd_pkg::IDX_W'(p), draw_edges(shape, wfcd_pkg::IDX_W'(p)), 1'b0);
        end
        sent += PROCS;
      end
      burst = $urandom_range(5, 40);
      repeat (burst) begin
        automatic bit [wfcd_pkg::IDX_W-1:0] idx =
          wfcd_pkg::IDX_W'($urandom_range(0, PROCS - 1));
        send_word(idx, draw_edges(shape, idx), $urandom_range(0, 2) == 0);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();

    repeat (SETTLE_CYC) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[wait_for_cycle_detect.f]
hw/rtl/wfcd_pkg.sv
hw/rtl/wfcd_front.sv
hw/rtl/wfcd_engine.sv
hw/rtl/wait_for_cycle_detect.sv
verif/wait_for_cycle_detect_tb.sv
